FILE: src/tcw_pkg.sv
// shared constants, codes and control/status structs for the text console writer
// no dependencies; used by tcw_ctrl, tcw_datapath and text_console_writer
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELLS      = ROWS * COLUMNS;
	localparam int COPY_CELLS = COLUMNS * (ROWS - 1);
	localparam int CELL_AW    = $clog2(CELLS);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS);

	localparam int KIND_W  = 3;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 4;
	localparam int ADDR_W  = 11;
	localparam int POS_W   = 11;
	localparam int DATA_W  = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
	localparam logic [CHAR_W-1:0] NL_CODE    = 8'd10;
	localparam logic [CHAR_W-1:0] CR_CODE    = 8'd13;

	localparam logic [COLOR_W-1:0] RESET_FG = 4'hF;
	localparam logic [COLOR_W-1:0] RESET_BG = 4'h0;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUT   = 3'd0,
		KIND_BS    = 3'd1,
		KIND_BACK  = 3'd2,
		KIND_CLEAR = 3'd3,
		KIND_READ  = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLANK_FG = 1'd0,
		CFG_BLANK_BG = 1'd1
	} cfg_reg_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // take the request in
		logic exec;       // run the cursor and cell update
		logic fill_init;  // write reset blank at the sweep count
		logic fill;       // write configured blank at the sweep count
		logic copy;       // move one cell up one row
		logic blank_row;  // write configured blank into the bottom row
		logic cnt_clr;
		logic cnt_inc;
		logic finish;     // present the result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_clear;
		logic need_scroll;
		logic cnt_last;      // sweep count at the last cell
		logic cnt_copy_end;  // sweep count one past the copied range
	} stat_t;

endpackage

FILE: src/tcw_ctrl.sv
// sequencer for the text console writer: reset clearing pass, command run,
// clear fill, scroll copy and bottom row blanking; depends on tcw_pkg
module tcw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  tcw_pkg::stat_t stat,
	output tcw_pkg::cmd_t  cmd,
	output logic           busy
);

	typedef enum logic [5:0] {
		S_INIT  = 6'b000001,
		S_IDLE  = 6'b000010,
		S_EXEC  = 6'b000100,
		S_FILL  = 6'b001000,
		S_COPY  = 6'b010000,
		S_BLANK = 6'b100000
	} state_t;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.fill_init = 1'b1;
				cmd.cnt_inc   = 1'b1;
				if (stat.cnt_last) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_n  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec    = 1'b1;
				cmd.cnt_clr = 1'b1;
				priority if (stat.is_clear) begin
					state_n = S_FILL;
				end else if (stat.need_scroll) begin
					state_n = S_COPY;
				end else begin
					cmd.finish = 1'b1;
					state_n    = S_IDLE;
				end
			end
			S_FILL: begin
				cmd.fill    = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (stat.cnt_last) begin
					cmd.finish = 1'b1;
					state_n    = S_IDLE;
				end
			end
			S_COPY: begin
				cmd.copy = 1'b1;
				// count stays put at the end so the blank row starts right there
				if (stat.cnt_copy_end) begin
					state_n = S_BLANK;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			S_BLANK: begin
				cmd.blank_row = 1'b1;
				cmd.cnt_inc   = 1'b1;
				if (stat.cnt_last) begin
					cmd.finish = 1'b1;
					state_n    = S_IDLE;
				end
			end
			default: begin
				state_n = S_INIT;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

FILE: src/tcw_datapath.sv
// text console datapath: cell memory, cursor, sweep counter, blank colors,
// request registers and result registers; depends on tcw_pkg
module tcw_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tcw_pkg::cmd_t                       cmd,
	output tcw_pkg::stat_t                      stat,
	input  logic [tcw_pkg::KIND_W-1:0]          kind,
	input  logic [tcw_pkg::CHAR_W-1:0]          char_code,
	input  logic [tcw_pkg::COLOR_W-1:0]         fg,
	input  logic [tcw_pkg::COLOR_W-1:0]         bg,
	input  logic [tcw_pkg::ADDR_W-1:0]          cell_addr,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tcw_pkg::COLOR_W-1:0]         cfg_data,
	output logic                                done,
	output logic [tcw_pkg::POS_W-1:0]           cursor_pos,
	output logic [tcw_pkg::DATA_W-1:0]          cell_data
);

	localparam int AW = tcw_pkg::CELL_AW;

	logic [tcw_pkg::DATA_W-1:0] mem [tcw_pkg::CELLS];
	logic [tcw_pkg::DATA_W-1:0] rdata_q;

	logic [tcw_pkg::KIND_W-1:0]  kind_q;
	logic [tcw_pkg::CHAR_W-1:0]  char_q;
	logic [tcw_pkg::COLOR_W-1:0] fg_q, bg_q;
	logic                        rd_ok_q;

	logic [tcw_pkg::COLOR_W-1:0] blank_fg_q, blank_bg_q;
	logic [tcw_pkg::COL_W-1:0]   col_q, col_n, wcol;
	logic [tcw_pkg::ROW_W-1:0]   row_q, row_n;
	logic [tcw_pkg::POS_W-1:0]   pos_q, pos_n;
	logic [AW-1:0]               cnt_q;
	logic                        done_q;
	logic [tcw_pkg::DATA_W-1:0]  data_q;

	logic                        pos_upd, pos_zero, ex_wr, is_nl, at_last_col, at_last_row;
	logic [tcw_pkg::DATA_W-1:0]  blank_cell, reset_cell, ex_wdata;
	logic [AW-1:0]               ex_waddr, new_idx, raddr;
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [tcw_pkg::DATA_W-1:0]  mem_wdata;

	assign blank_cell = {blank_bg_q, blank_fg_q, tcw_pkg::SPACE_CODE};
	assign reset_cell = {tcw_pkg::RESET_BG, tcw_pkg::RESET_FG, tcw_pkg::SPACE_CODE};

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_fg_q <= tcw_pkg::RESET_FG;
			blank_bg_q <= tcw_pkg::RESET_BG;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tcw_pkg::CFG_BLANK_FG: blank_fg_q <= cfg_data;
				tcw_pkg::CFG_BLANK_BG: blank_bg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			char_q  <= char_code;
			fg_q    <= fg;
			bg_q    <= bg;
			rd_ok_q <= (32'(cell_addr) < 32'(tcw_pkg::CELLS));
		end
	end

	assign is_nl       = (char_q == tcw_pkg::NL_CODE) || (char_q == tcw_pkg::CR_CODE);
	assign at_last_col = (col_q == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
	assign at_last_row = (row_q == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));

	// cursor update for one request
	always_comb begin
		col_n    = col_q;
		row_n    = row_q;
		wcol     = col_q;
		pos_upd  = 1'b0;
		pos_zero = 1'b0;
		ex_wr    = 1'b0;
		ex_wdata = {bg_q, fg_q, char_q};
		unique case (kind_q)
			tcw_pkg::KIND_PUT: begin
				if (!is_nl) begin
					ex_wr = 1'b1;
				end
				if (!is_nl && !at_last_col) begin
					col_n   = col_q + tcw_pkg::COL_W'(1);
					pos_upd = 1'b1;
				end else begin
					// new line; on the bottom row the store scrolls instead
					if (!at_last_row) begin
						row_n = row_q + tcw_pkg::ROW_W'(1);
					end
					col_n   = tcw_pkg::COL_W'(1);
					pos_upd = 1'b1;
				end
			end
			tcw_pkg::KIND_BS: begin
				if (col_q != '0) begin
					col_n    = col_q - tcw_pkg::COL_W'(1);
					wcol     = col_n;
					ex_wr    = 1'b1;
					ex_wdata = blank_cell;
				end
			end
			tcw_pkg::KIND_BACK: begin
				if (col_q == '0) begin
					if (row_q != '0) begin
						col_n   = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
						row_n   = row_q - tcw_pkg::ROW_W'(1);
						pos_upd = 1'b1;
					end
				end else begin
					col_n   = col_q - tcw_pkg::COL_W'(1);
					pos_upd = 1'b1;
				end
			end
			tcw_pkg::KIND_CLEAR: begin
				col_n    = tcw_pkg::COL_W'(1);
				row_n    = '0;
				pos_zero = 1'b1;
			end
			default: ;
		endcase
	end

	assign ex_waddr = AW'(row_q) * AW'(tcw_pkg::COLUMNS) + AW'(wcol);
	assign new_idx  = AW'(row_n) * AW'(tcw_pkg::COLUMNS) + AW'(col_n);
	assign pos_n    = tcw_pkg::POS_W'(new_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= tcw_pkg::COL_W'(1);
			row_q <= '0;
			pos_q <= '0;
		end else if (cmd.exec) begin
			col_q <= col_n;
			row_q <= row_n;
			if (pos_zero) begin
				pos_q <= '0;
			end else if (pos_upd) begin
				pos_q <= pos_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	assign stat.is_clear     = (kind_q == tcw_pkg::KIND_CLEAR);
	assign stat.need_scroll  = (kind_q == tcw_pkg::KIND_PUT) && (is_nl || at_last_col)
	                           && at_last_row;
	assign stat.cnt_last     = (cnt_q == AW'(tcw_pkg::CELLS - 1));
	assign stat.cnt_copy_end = (cnt_q == AW'(tcw_pkg::COPY_CELLS));

	// one write port, one read port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = blank_cell;
		priority if (cmd.fill_init) begin
			mem_we    = 1'b1;
			mem_wdata = reset_cell;
		end else if (cmd.fill || cmd.blank_row) begin
			mem_we = 1'b1;
		end else if (cmd.copy) begin
			// read data comes from a register, so the write trails the copy count by one cell
			mem_we    = (cnt_q != '0);
			mem_waddr = cnt_q - AW'(1);
			mem_wdata = rdata_q;
		end else if (cmd.exec) begin
			mem_we    = ex_wr;
			mem_waddr = ex_waddr;
			mem_wdata = ex_wdata;
		end
	end

	assign raddr = cmd.copy ? (cnt_q + AW'(tcw_pkg::COLUMNS)) : AW'(cell_addr);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[raddr];
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			data_q <= ((kind_q == tcw_pkg::KIND_READ) && rd_ok_q) ? rdata_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign done       = done_q;
	assign cursor_pos = pos_q;
	assign cell_data  = data_q;

endmodule

FILE: src/text_console_writer.sv
// text console writer top level: sequencer plus datapath with the cell memory
// depends on tcw_pkg, tcw_ctrl and tcw_datapath
//
// channel   handshake                  payload
// request   start, busy                kind, char_code, fg, bg, cell_addr
// result    done (one-cycle strobe)    cursor_pos, cell_data
// config    cfg_valid, cfg_ready       cfg_index, cfg_data
//
// put char without scroll, backspace, cursor back, read cell, unused kinds: the
// exec state, then the done register; single-port-write memory sets the sweeps
// clear: exec, then a fill of all COLUMNS*ROWS cells, one cell written per cycle
// scroll: exec, then the row copy, then bottom row blanking
// after reset busy stays high while all COLUMNS*ROWS cells of the memory are
// blanked; config writes are taken throughout, cfg_ready is always high
// results cannot be stalled; a new request may be taken in the done cycle
module text_console_writer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [tcw_pkg::KIND_W-1:0]        kind,
	input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
	input  logic [tcw_pkg::COLOR_W-1:0]       fg,
	input  logic [tcw_pkg::COLOR_W-1:0]       bg,
	input  logic [tcw_pkg::ADDR_W-1:0]        cell_addr,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tcw_pkg::COLOR_W-1:0]       cfg_data,
	output logic                              done,
	output logic [tcw_pkg::POS_W-1:0]         cursor_pos,
	output logic [tcw_pkg::DATA_W-1:0]        cell_data
);

	tcw_pkg::cmd_t  cmd;
	tcw_pkg::stat_t stat;

	tcw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	tcw_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.kind       (kind),
		.char_code  (char_code),
		.fg         (fg),
		.bg         (bg),
		.cell_addr  (cell_addr),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.done       (done),
		.cursor_pos (cursor_pos),
		.cell_data  (cell_data)
	);

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for text_console_writer: queue-fed driver, clocked monitor
// and an in-bench screen/cursor predictor; depends on tcw_pkg and the text_console_writer rtl
module testbench;

	localparam logic [tcw_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd5;
	localparam logic [tcw_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;
	localparam int PHASES = 5;
	localparam int PHASE_ITEMS = 200;

	typedef struct {
		logic [tcw_pkg::KIND_W-1:0]  kind;
		logic [tcw_pkg::CHAR_W-1:0]  ch;
		logic [tcw_pkg::COLOR_W-1:0] fg;
		logic [tcw_pkg::COLOR_W-1:0] bg;
		logic [tcw_pkg::ADDR_W-1:0]  addr;
	} console_cmd_t;

	typedef struct {
		logic [tcw_pkg::POS_W-1:0]  pos;
		logic [tcw_pkg::DATA_W-1:0] data;
	} console_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [tcw_pkg::KIND_W-1:0] kind = '0;
	logic [tcw_pkg::CHAR_W-1:0] char_code = '0;
	logic [tcw_pkg::COLOR_W-1:0] fg = '0;
	logic [tcw_pkg::COLOR_W-1:0] bg = '0;
	logic [tcw_pkg::ADDR_W-1:0] cell_addr = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tcw_pkg::COLOR_W-1:0] cfg_data = '0;
	logic done;
	logic [tcw_pkg::POS_W-1:0] cursor_pos;
	logic [tcw_pkg::DATA_W-1:0] cell_data;

	text_console_writer dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .char_code(char_code), .fg(fg), .bg(bg), .cell_addr(cell_addr),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .cursor_pos(cursor_pos), .cell_data(cell_data)
	);

	always #4 clk = ~clk;

	// predicted screen, cursor and blank colors
	logic [tcw_pkg::DATA_W-1:0] screen [tcw_pkg::CELLS];
	int cur_col;
	int cur_row;
	logic [tcw_pkg::POS_W-1:0] shown_pos;
	logic [tcw_pkg::COLOR_W-1:0] blank_fg;
	logic [tcw_pkg::COLOR_W-1:0] blank_bg;

	console_cmd_t cmd_q[$];
	console_report_t report_q[$];
	int items_queued = 0;
	int items_taken = 0;
	logic req_taken = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	console_cmd_t next_cmd;

	int errors = 0;
	int n_checked = 0;
	int n_scrolls = 0;
	int n_clears = 0;
	int n_reads = 0;
	int n_cfg = 0;

	task automatic note_mismatch(input string msg);
		errors++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic advance_line(input logic [tcw_pkg::DATA_W-1:0] blank);
		if (cur_row < tcw_pkg::ROWS - 1) begin
			cur_row++;
		end else begin
			for (int i = 0; i < tcw_pkg::COPY_CELLS; i++)
				screen[i] = screen[i + tcw_pkg::COLUMNS];
			for (int i = tcw_pkg::COPY_CELLS; i < tcw_pkg::CELLS; i++)
				screen[i] = blank;
			n_scrolls++;
		end
		cur_col = 1;
		shown_pos = tcw_pkg::POS_W'(cur_row * tcw_pkg::COLUMNS + cur_col);
	endtask

	task automatic blank_screen(input logic [tcw_pkg::DATA_W-1:0] blank);
		for (int i = 0; i < tcw_pkg::CELLS; i++)
			screen[i] = blank;
	endtask

	task automatic console_exec(input console_cmd_t c, output console_report_t r);
		logic [tcw_pkg::DATA_W-1:0] blank;
		blank = {blank_bg, blank_fg, tcw_pkg::SPACE_CODE};
		r.data = '0;
		unique case (c.kind)
			tcw_pkg::KIND_PUT: begin
				if (c.ch == tcw_pkg::NL_CODE || c.ch == tcw_pkg::CR_CODE) begin
					advance_line(blank);
				end else begin
					screen[cur_row * tcw_pkg::COLUMNS + cur_col] = {c.bg, c.fg, c.ch};
					if (cur_col < tcw_pkg::COLUMNS - 1) begin
						cur_col++;
						shown_pos = tcw_pkg::POS_W'(cur_row * tcw_pkg::COLUMNS + cur_col);
					end else begin
						advance_line(blank);
					end
				end
			end
			tcw_pkg::KIND_BS: begin
				// position report is left alone on backspace
				if (cur_col != 0) begin
					cur_col--;
					screen[cur_row * tcw_pkg::COLUMNS + cur_col] = blank;
				end
			end
			tcw_pkg::KIND_BACK: begin
				if (cur_col == 0) begin
					if (cur_row != 0) begin
						cur_col = tcw_pkg::COLUMNS - 1;
						cur_row--;
						shown_pos = tcw_pkg::POS_W'(cur_row * tcw_pkg::COLUMNS + cur_col);
					end
				end else begin
					cur_col--;
					shown_pos = tcw_pkg::POS_W'(cur_row * tcw_pkg::COLUMNS + cur_col);
				end
			end
			tcw_pkg::KIND_CLEAR: begin
				cur_col = 1;
				cur_row = 0;
				blank_screen(blank);
				shown_pos = '0;
				n_clears++;
			end
			tcw_pkg::KIND_READ: begin
				if (c.addr < tcw_pkg::CELLS) begin
					r.data = screen[c.addr];
					n_reads++;
				end
			end
			default: ;
		endcase
		r.pos = shown_pos;
	endtask

	initial begin
		cur_col = 1;
		cur_row = 0;
		shown_pos = '0;
		blank_fg = tcw_pkg::RESET_FG;
		blank_bg = tcw_pkg::RESET_BG;
		blank_screen({tcw_pkg::RESET_BG, tcw_pkg::RESET_FG, tcw_pkg::SPACE_CODE});
	end

	// monitor: checks results, predicts accepted requests, tracks register writes
	always @(posedge clk) begin
		console_report_t want;
		console_report_t pred;
		console_cmd_t seen;
		req_taken = 1'b0;
		if (arst_n) begin
			if (done) begin
				if (report_q.size() == 0) begin
					note_mismatch($sformatf("result with no request pending: pos %0d data %h",
						cursor_pos, cell_data));
				end else begin
					want = report_q.pop_front();
					n_checked++;
					if (cursor_pos !== want.pos)
						note_mismatch($sformatf("request %0d cursor_pos %0d, want %0d",
							n_checked, cursor_pos, want.pos));
					if (cell_data !== want.data)
						note_mismatch($sformatf("request %0d cell_data %h, want %h",
							n_checked, cell_data, want.data));
				end
			end
			if (start && busy === 1'b0) begin
				seen = '{kind, char_code, fg, bg, cell_addr};
				console_exec(seen, pred);
				report_q.push_back(pred);
				items_taken++;
				req_taken = 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == tcw_pkg::CFG_BLANK_FG)
					blank_fg = cfg_data;
				else
					blank_bg = cfg_data;
				n_cfg++;
			end
		end
	end

	// driver: bursts of requests separated by random gaps
	always @(negedge clk) begin
		if (!start || req_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (cmd_q.size() > 0) begin
				next_cmd = cmd_q.pop_front();
				start <= 1'b1;
				kind <= next_cmd.kind;
				char_code <= next_cmd.ch;
				fg <= next_cmd.fg;
				bg <= next_cmd.bg;
				cell_addr <= next_cmd.addr;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic push_cmd(input logic [tcw_pkg::KIND_W-1:0] k,
			input logic [tcw_pkg::CHAR_W-1:0] ch,
			input logic [tcw_pkg::COLOR_W-1:0] f, input logic [tcw_pkg::COLOR_W-1:0] b,
			input logic [tcw_pkg::ADDR_W-1:0] a);
		cmd_q.push_back('{k, ch, f, b, a});
		items_queued++;
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (items_taken != items_queued || report_q.size() != 0 || busy !== 1'b0);
	endtask

	task automatic write_reg(input tcw_pkg::cfg_reg_t idx,
			input logic [tcw_pkg::COLOR_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_random(input logic [tcw_pkg::KIND_W-1:0] k);
		push_cmd(k, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
			tcw_pkg::COLOR_W'($urandom_range(0, 15)), tcw_pkg::COLOR_W'($urandom_range(0, 15)),
			tcw_pkg::ADDR_W'($urandom_range(0, 2047)));
	endtask

	task automatic push_newline();
		push_cmd(tcw_pkg::KIND_PUT, $urandom_range(0, 1) ? tcw_pkg::NL_CODE : tcw_pkg::CR_CODE,
			tcw_pkg::COLOR_W'($urandom_range(0, 15)), tcw_pkg::COLOR_W'($urandom_range(0, 15)),
			tcw_pkg::ADDR_W'($urandom_range(0, 2047)));
	endtask

	// random traffic built from text lines, newline runs, edits, reads, clears and unused kinds
	task automatic gen_random(input int n);
		int made;
		int sel;
		int len;
		made = 0;
		while (made < n) begin
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				len = $urandom_range(1, 90);
				for (int i = 0; i < len; i++)
					push_random(tcw_pkg::KIND_PUT);
				made += len;
				if ($urandom_range(0, 1)) begin
					push_newline();
					made++;
				end
			end else if (sel < 55) begin
				len = $urandom_range(3, 30);
				for (int i = 0; i < len; i++)
					push_newline();
				made += len;
			end else if (sel < 70) begin
				len = $urandom_range(1, 12);
				for (int i = 0; i < len; i++)
					push_random($urandom_range(0, 1) ? tcw_pkg::KIND_BS : tcw_pkg::KIND_BACK);
				made += len;
			end else if (sel < 90) begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					push_cmd(tcw_pkg::KIND_READ, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
						tcw_pkg::COLOR_W'($urandom_range(0, 15)),
						tcw_pkg::COLOR_W'($urandom_range(0, 15)),
						tcw_pkg::ADDR_W'(($urandom_range(0, 7) == 0) ?
						$urandom_range(0, 2047) : $urandom_range(0, tcw_pkg::CELLS - 1)));
				made += len;
			end else if (sel < 94) begin
				push_random(tcw_pkg::KIND_CLEAR);
				made++;
			end else if (sel < 97) begin
				push_random(tcw_pkg::KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)));
				made++;
			end else begin
				push_random(tcw_pkg::KIND_W'($urandom_range(0, 7)));
				made++;
			end
		end
	endtask

	initial begin
		logic [tcw_pkg::COLOR_W-1:0] set_fg [PHASES];
		logic [tcw_pkg::COLOR_W-1:0] set_bg [PHASES];
		set_fg = '{4'h0, 4'hF, 4'h0, 4'h0, 4'hF};
		set_bg = '{4'h0, 4'hF, 4'hF, 4'h0, 4'h0};
		set_fg[3] = tcw_pkg::COLOR_W'($urandom_range(0, 15));
		set_bg[3] = tcw_pkg::COLOR_W'($urandom_range(0, 15));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait_idle();

		// directed: reset contents, range edges, cursor corners, newline and wrap
		push_cmd(tcw_pkg::KIND_READ, 8'h00, 4'h0, 4'h0, 11'd0);
		push_cmd(tcw_pkg::KIND_READ, 8'hFF, 4'hF, 4'hF, tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1));
		push_cmd(tcw_pkg::KIND_READ, 8'h00, 4'h0, 4'h0, tcw_pkg::ADDR_W'(tcw_pkg::CELLS));
		push_cmd(tcw_pkg::KIND_READ, 8'h00, 4'h0, 4'h0, 11'h7FF);
		push_cmd(tcw_pkg::KIND_PUT, 8'h41, 4'h0, 4'hF, 11'd0);
		push_cmd(tcw_pkg::KIND_PUT, 8'hFF, 4'hF, 4'h0, 11'h7FF);
		push_cmd(tcw_pkg::KIND_PUT, 8'h00, 4'hA, 4'h5, 11'd0);
		push_cmd(tcw_pkg::KIND_BS, 8'h00, 4'h0, 4'h0, 11'd0);
		push_cmd(tcw_pkg::KIND_BACK, 8'h00, 4'h0, 4'h0, 11'd0);
		push_cmd(tcw_pkg::KIND_BACK, 8'h00, 4'h0, 4'h0, 11'd0);
		// back to column 0 of row 0, where back and backspace then leave everything alone
		push_cmd(tcw_pkg::KIND_BACK, 8'h00, 4'h0, 4'h0, 11'd0);
		push_cmd(tcw_pkg::KIND_BACK, 8'h00, 4'h0, 4'h0, 11'd0);
		push_cmd(tcw_pkg::KIND_BS, 8'h00, 4'h0, 4'h0, 11'd0);
		push_cmd(tcw_pkg::KIND_PUT, 8'h5A, 4'h5, 4'hA, 11'd0);
		push_cmd(tcw_pkg::KIND_PUT, tcw_pkg::NL_CODE, 4'h0, 4'h0, 11'd0);
		push_cmd(tcw_pkg::KIND_PUT, tcw_pkg::CR_CODE, 4'h0, 4'h0, 11'd0);
		push_cmd(tcw_pkg::KIND_BACK, 8'h00, 4'h0, 4'h0, 11'd0);
		push_cmd(tcw_pkg::KIND_BACK, 8'h00, 4'h0, 4'h0, 11'd0);
		// last column forces a new line
		push_cmd(tcw_pkg::KIND_PUT, 8'h7E, 4'h3, 4'hC, 11'd0);
		push_cmd(tcw_pkg::KIND_READ, 8'h00, 4'h0, 4'h0,
			tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS * 2 - 1));
		push_cmd(KIND_SPARE_LO, 8'hFF, 4'hF, 4'hF, 11'h7FF);
		push_cmd(KIND_SPARE_HI, 8'h00, 4'h0, 4'h0, 11'd0);
		push_cmd(tcw_pkg::KIND_CLEAR, 8'h00, 4'h0, 4'h0, 11'd0);
		push_cmd(tcw_pkg::KIND_READ, 8'h00, 4'h0, 4'h0, 11'd1);
		push_cmd(tcw_pkg::KIND_READ, 8'h00, 4'h0, 4'h0, tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1));
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			write_reg(tcw_pkg::CFG_BLANK_FG, set_fg[p]);
			write_reg(tcw_pkg::CFG_BLANK_BG, set_bg[p]);
			gen_random(PHASE_ITEMS);
			wait_idle();
		end

		repeat (10) @(negedge clk);
		$display("checked %0d requests: %0d scrolls, %0d clears, %0d in-range cell reads",
			n_checked, n_scrolls, n_clears, n_reads);
		$display("%0d blank color register writes over %0d settings", n_cfg, PHASES);
		if (errors == 0)
			$display("text_console_writer: match");
		else
			$display("text_console_writer: mismatch");
		$finish;
	end

	initial begin
		#100ms;
		$display("timeout with %0d results still pending", report_q.size());
		$display("text_console_writer: mismatch");
		$finish;
	end

endmodule

FILE: filelist.f
src/tcw_pkg.sv
src/tcw_ctrl.sv
src/tcw_datapath.sv
src/text_console_writer.sv
tb/testbench.sv
